// ----- design/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   // Word format
   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int PROD_BITS     = 2 * WORD_BITS;
   localparam int WIDE_BITS     = 2 * WORD_BITS + 2;
   localparam int REM_BITS      = 2 * WORD_BITS + 1;

   // Saturation bounds, sign-extended to the wide working width
   localparam logic signed [WIDE_BITS-1:0] WIDE_MAX =
      {{(WORD_BITS + 3){1'b0}}, {(WORD_BITS - 1){1'b1}}};
   localparam logic signed [WIDE_BITS-1:0] WIDE_MIN =
      {{(WORD_BITS + 3){1'b1}}, {(WORD_BITS - 1){1'b0}}};

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_NEG  = 4'd4,
      OP_CONJ = 4'd5,
      OP_ABS  = 4'd6,
      OP_EQ   = 4'd7,
      OP_LT   = 4'd8,
      OP_LE   = 4'd9,
      OP_GT   = 4'd10,
      OP_GE   = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   typedef struct packed {
      logic [3:0]                  op;
      logic signed [WORD_BITS-1:0] x_real;
      logic signed [WORD_BITS-1:0] x_imag;
      logic signed [WORD_BITS-1:0] y_real;
      logic signed [WORD_BITS-1:0] y_imag;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_real;
      logic signed [WORD_BITS-1:0] res_imag;
      logic                        cmp_true;
      logic [1:0]                  status;
   } rsp_word_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] val;
      logic                 flag;
   } sat_type;

   // State carried through the divide / square-root stages
   typedef struct packed {
      logic [3:0]             op;
      rsp_word_type           pre;
      logic                   neg_re;
      logic                   neg_im;
      logic                   ovf_re;
      logic                   ovf_im;
      logic                   den_zero;
      logic [PROD_BITS-1:0]   den;
      logic [REM_BITS-1:0]    rem_re;
      logic [REM_BITS-1:0]    rem_im;
      logic [WORD_BITS-1:0]   quo_re;
      logic [WORD_BITS-1:0]   quo_im;
      logic [WORD_BITS+1:0]   sq_rem;
      logic [WORD_BITS-1:0]   sq_root;
      logic [PROD_BITS-1:0]   sq_val;
   } iter_type;

   // Clamp a wide signed value into one word
   function automatic sat_type sat_word(input logic signed [WIDE_BITS-1:0] v);
      sat_type r;
      if (v > WIDE_MAX) begin
         r.val  = {1'b0, {(WORD_BITS - 1){1'b1}}};
         r.flag = 1'b1;
      end else if (v < WIDE_MIN) begin
         r.val  = {1'b1, {(WORD_BITS - 1){1'b0}}};
         r.flag = 1'b1;
      end else begin
         r.val  = v[WORD_BITS-1:0];
         r.flag = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- design/complex_arithmetic_unit_core.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Pipelined signed fixed-point complex ALU.
// ----------------------------------------------------------------------------
// Accepts one word per cycle when the output side does not stall, and returns
// each result from the last stage; the depth is set by the divider and
// square root, which resolve one result bit per stage.
// Every opcode takes the same path, so results leave in the order given.
// A stalled output fills empty stages first, so input is still taken while a
// result waits, as long as an empty stage remains.
module complex_arithmetic_unit_core #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cau_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cau_pkg::rsp_word_type rsp_word
);
   import cau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int NS = WORD_BITS + 4;

   logic [NS-1:0] v_ff, v_in;
   logic [NS:0]   en;
   iter_type      front_word, iter_word;

   // Stage advance: a stage loads when empty or when the next one moves
   assign en[NS] = rsp_ready;
   for (genvar k = 0; k < NS; k++) begin : g_en
      assign en[k] = ~v_ff[k] | en[k+1];
   end

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (k == 0) v_in[k] = en[k] ? req_valid : v_ff[k];
         else        v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NS-1];

   cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .stage_en  (en[2:0]),
      .req_word  (req_word),
      .iter_word (front_word)
   );

   cau_iter u_iter (
      .clock         (clock),
      .stage_en      (en[W+2:3]),
      .iter_in_word  (front_word),
      .iter_out_word (iter_word)
   );

   cau_back u_back (
      .clock     (clock),
      .stage_en  (en[W+3]),
      .iter_word (iter_word),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   a_div0_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == ST_DIV0) |->
         (rsp_word.res_real == '0) && (rsp_word.res_imag == '0))
      else $error("divide by zero result not cleared");

   a_cmp_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.cmp_true |->
         (rsp_word.res_real == '0) && (rsp_word.res_imag == '0) &&
         (rsp_word.status == ST_OK))
      else $error("comparison result carries data");

   a_empty_out_ready : assert property (@(posedge clock) disable iff (reset)
      !v_ff[NS-1] |-> req_ready)
      else $error("input refused with empty output stage");
`endif

endmodule

// ----- design/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front
// Three stages: products, sums, then rounding and divide/sqrt setup.
// ----------------------------------------------------------------------------
module cau_front #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic [2:0]            stage_en,
   input  cau_pkg::req_word_type req_word,
   output cau_pkg::iter_type     iter_word
);
   import cau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int PW = PROD_BITS;
   localparam int XW = WIDE_BITS;
   localparam int CW = 3 * WORD_BITS + 2;
   localparam logic signed [XW-1:0] RND = {{(XW - 1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

   typedef struct packed {
      logic [3:0]           op;
      rsp_word_type         pre;
      logic signed [PW-1:0] ac;
      logic signed [PW-1:0] bd;
      logic signed [PW-1:0] ad;
      logic signed [PW-1:0] bc;
      logic signed [PW-1:0] cc;
      logic signed [PW-1:0] dd;
      logic signed [PW-1:0] aa;
      logic signed [PW-1:0] bb;
   } s1_type;

   typedef struct packed {
      logic [3:0]         op;
      rsp_word_type       pre;
      logic signed [PW:0] mre;
      logic signed [PW:0] mim;
      logic signed [PW:0] nre;
      logic signed [PW:0] nim;
      logic signed [PW:0] den;
      logic [PW-1:0]      sq;
   } s2_type;

   s1_type   s1_in, s1_ff;
   s2_type   s2_in, s2_ff;
   iter_type s3_in, s3_ff;

   // Stage 1: partial products and the simple operations
   always_comb begin
      logic signed [W-1:0] a, b, c, d;
      sat_type             sr, si;
      a = req_word.x_real;
      b = req_word.x_imag;
      c = req_word.y_real;
      d = req_word.y_imag;
      sr = '0;
      si = '0;
      s1_in     = '0;
      s1_in.op  = req_word.op;
      s1_in.ac  = PW'(a) * PW'(c);
      s1_in.bd  = PW'(b) * PW'(d);
      s1_in.ad  = PW'(a) * PW'(d);
      s1_in.bc  = PW'(b) * PW'(c);
      s1_in.cc  = PW'(c) * PW'(c);
      s1_in.dd  = PW'(d) * PW'(d);
      s1_in.aa  = PW'(a) * PW'(a);
      s1_in.bb  = PW'(b) * PW'(b);
      case (op_type'(req_word.op))
         OP_ADD: begin
            sr = sat_word(XW'(a) + XW'(c));
            si = sat_word(XW'(b) + XW'(d));
         end
         OP_SUB: begin
            sr = sat_word(XW'(a) - XW'(c));
            si = sat_word(XW'(b) - XW'(d));
         end
         OP_NEG: begin
            sr = sat_word(-XW'(a));
            si = sat_word(-XW'(b));
         end
         OP_CONJ: begin
            sr = sat_word(XW'(a));
            si = sat_word(-XW'(b));
         end
         OP_EQ: s1_in.pre.cmp_true = (a == c) && (b == d);
         OP_LT: s1_in.pre.cmp_true = (a < c) || ((a == c) && (b < d));
         OP_LE: s1_in.pre.cmp_true = (a < c) || ((a == c) && (b <= d));
         OP_GT: s1_in.pre.cmp_true = (a > c) || ((a == c) && (b > d));
         OP_GE: s1_in.pre.cmp_true = (a > c) || ((a == c) && (b >= d));
         default: ;
      endcase
      s1_in.pre.res_real = sr.val;
      s1_in.pre.res_imag = si.val;
      s1_in.pre.status   = (sr.flag || si.flag) ? ST_SAT : ST_OK;
   end

   // Stage 2: combine products
   always_comb begin
      s2_in     = '0;
      s2_in.op  = s1_ff.op;
      s2_in.pre = s1_ff.pre;
      s2_in.mre = (PW + 1)'(s1_ff.ac) - (PW + 1)'(s1_ff.bd);
      s2_in.mim = (PW + 1)'(s1_ff.ad) + (PW + 1)'(s1_ff.bc);
      s2_in.nre = (PW + 1)'(s1_ff.ac) + (PW + 1)'(s1_ff.bd);
      s2_in.nim = (PW + 1)'(s1_ff.bc) - (PW + 1)'(s1_ff.ad);
      s2_in.den = (PW + 1)'(s1_ff.cc) + (PW + 1)'(s1_ff.dd);
      s2_in.sq  = $unsigned(s1_ff.aa) + $unsigned(s1_ff.bb);
   end

   // Stage 3: product rounding, divider and square-root setup
   always_comb begin
      logic signed [XW-1:0] sh_re, sh_im;
      sat_type              sr, si;
      logic [PW:0]          mag_re, mag_im;
      logic [CW-1:0]        num_re, num_im, den_sh;
      sh_re  = (XW'(s2_ff.mre) + RND) >>> FRAC_BITS;
      sh_im  = (XW'(s2_ff.mim) + RND) >>> FRAC_BITS;
      sr     = sat_word(sh_re);
      si     = sat_word(sh_im);
      mag_re = s2_ff.nre[PW] ? $unsigned(-s2_ff.nre) : $unsigned(s2_ff.nre);
      mag_im = s2_ff.nim[PW] ? $unsigned(-s2_ff.nim) : $unsigned(s2_ff.nim);
      num_re = CW'(mag_re) << FRAC_BITS;
      num_im = CW'(mag_im) << FRAC_BITS;
      den_sh = CW'(s2_ff.den[PW-1:0]) << W;

      s3_in          = '0;
      s3_in.op       = s2_ff.op;
      s3_in.pre      = s2_ff.pre;
      if (op_type'(s2_ff.op) == OP_MUL) begin
         s3_in.pre.res_real = sr.val;
         s3_in.pre.res_imag = si.val;
         s3_in.pre.status   = (sr.flag || si.flag) ? ST_SAT : ST_OK;
      end
      s3_in.neg_re   = s2_ff.nre[PW];
      s3_in.neg_im   = s2_ff.nim[PW];
      s3_in.ovf_re   = num_re >= den_sh;
      s3_in.ovf_im   = num_im >= den_sh;
      s3_in.den_zero = s2_ff.den == '0;
      s3_in.den      = s2_ff.den[PW-1:0];
      s3_in.rem_re   = REM_BITS'(num_re >> W);
      s3_in.rem_im   = REM_BITS'(num_im >> W);
      s3_in.quo_re   = num_re[W-1:0];
      s3_in.quo_im   = num_im[W-1:0];
      s3_in.sq_val   = s2_ff.sq;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) s1_ff <= s1_in;
      if (stage_en[1]) s2_ff <= s2_in;
      if (stage_en[2]) s3_ff <= s3_in;
   end

   assign iter_word = s3_ff;

endmodule

// ----- design/cau_iter.sv -----
// ----------------------------------------------------------------------------
// cau_iter
// Bit-per-stage restoring divider (two lanes) and square root.
// ----------------------------------------------------------------------------
module cau_iter (
   input  logic                             clock,
   input  logic [cau_pkg::WORD_BITS-1:0]    stage_en,
   input  cau_pkg::iter_type                iter_in_word,
   output cau_pkg::iter_type                iter_out_word
);
   import cau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int PW = PROD_BITS;

   iter_type stage_ff [W];
   iter_type stage_in [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      iter_type src;

      if (k == 0) begin : g_first
         assign src = iter_in_word;
      end else begin : g_next
         assign src = stage_ff[k-1];
      end

      // One quotient bit per lane and one root bit
      always_comb begin
         logic [REM_BITS-1:0] t_re, t_im, den_ext;
         logic [W+1:0]        t_sq, trial;
         logic                q_re, q_im, q_sq;
         den_ext = REM_BITS'(src.den);
         t_re    = {src.rem_re[REM_BITS-2:0], src.quo_re[W-1]};
         t_im    = {src.rem_im[REM_BITS-2:0], src.quo_im[W-1]};
         t_sq    = {src.sq_rem[W-1:0], src.sq_val[PW-1:PW-2]};
         trial   = {src.sq_root, 2'b01};
         q_re    = t_re >= den_ext;
         q_im    = t_im >= den_ext;
         q_sq    = t_sq >= trial;
         stage_in[k]         = src;
         stage_in[k].rem_re  = q_re ? t_re - den_ext : t_re;
         stage_in[k].rem_im  = q_im ? t_im - den_ext : t_im;
         stage_in[k].quo_re  = {src.quo_re[W-2:0], q_re};
         stage_in[k].quo_im  = {src.quo_im[W-2:0], q_im};
         stage_in[k].sq_rem  = q_sq ? t_sq - trial : t_sq;
         stage_in[k].sq_root = {src.sq_root[W-2:0], q_sq};
         stage_in[k].sq_val  = {src.sq_val[PW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (stage_en[k]) stage_ff[k] <= stage_in[k];
      end
   end

   assign iter_out_word = stage_ff[W-1];

endmodule

// ----- design/cau_back.sv -----
// ----------------------------------------------------------------------------
// cau_back
// Final stage: quotient sign and saturation, magnitude clamp, output word.
// ----------------------------------------------------------------------------
module cau_back (
   input  logic                  clock,
   input  logic                  stage_en,
   input  cau_pkg::iter_type     iter_word,
   output cau_pkg::rsp_word_type rsp_word
);
   import cau_pkg::*;

   localparam int W = WORD_BITS;
   localparam logic [W-1:0] MAX_POS = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0] MIN_NEG = {1'b1, {(W - 1){1'b0}}};

   rsp_word_type rsp_in, rsp_ff;

   // Signed quotient from its magnitude, clamped to one word
   function automatic sat_type fix_quot(input logic neg, input logic ovf,
                                        input logic [W-1:0] q);
      sat_type r;
      if (neg) begin
         if (ovf || (q > MIN_NEG)) begin
            r.val  = MIN_NEG;
            r.flag = 1'b1;
         end else begin
            r.val  = -q;
            r.flag = 1'b0;
         end
      end else begin
         if (ovf || q[W-1]) begin
            r.val  = MAX_POS;
            r.flag = 1'b1;
         end else begin
            r.val  = q;
            r.flag = 1'b0;
         end
      end
      return r;
   endfunction

   always_comb begin
      sat_type qr, qi;
      qr     = fix_quot(iter_word.neg_re, iter_word.ovf_re, iter_word.quo_re);
      qi     = fix_quot(iter_word.neg_im, iter_word.ovf_im, iter_word.quo_im);
      rsp_in = iter_word.pre;
      case (op_type'(iter_word.op))
         OP_DIV: begin
            if (iter_word.den_zero) begin
               rsp_in = '0;
               rsp_in.status = ST_DIV0;
            end else begin
               rsp_in.res_real = qr.val;
               rsp_in.res_imag = qi.val;
               rsp_in.cmp_true = 1'b0;
               rsp_in.status   = (qr.flag || qi.flag) ? ST_SAT : ST_OK;
            end
         end
         OP_ABS: begin
            rsp_in.res_real = iter_word.sq_root[W-1] ? MAX_POS : iter_word.sq_root;
            rsp_in.res_imag = '0;
            rsp_in.cmp_true = 1'b0;
            rsp_in.status   = iter_word.sq_root[W-1] ? ST_SAT : ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en) rsp_ff <= rsp_in;
   end

   assign rsp_word = rsp_ff;

endmodule

// ----- verif/tb_complex_arithmetic_unit_core.sv -----
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit_core
// Self-checking bench for the pipelined fixed-point complex ALU.
// ----------------------------------------------------------------------------
// Directed words cover the operand extremes, every opcode, overflow,
// divide by zero and the unused opcodes. Random words follow, with random
// gaps on both sides and one long output stall that fills the pipeline.
// Each result is checked against a behavioral model in arrival order.
module tb_complex_arithmetic_unit_core;
   import cau_pkg::*;

   localparam int FRAC      = FRAC_BITS_DEF;
   localparam int WD_LIMIT  = 20000;
   localparam int DRAIN_CYC = 200;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   rsp_word_type expected_q[$];
   int           n_errors = 0;
   int           n_sent = 0;
   int           n_checked = 0;
   int           idle_cyc = 0;
   bit           long_stall = 1'b0;
   bit           drv_gaps = 1'b1;
   int           op_seen[16];

   complex_arithmetic_unit_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // Clamp a wide value into one word, flag overflow
   function automatic logic [WORD_BITS-1:0] clamp_word(input logic signed [127:0] v,
                                                     inout bit ovf);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = (128'sd1 <<< (WORD_BITS - 1)) - 1;
      lo = -(128'sd1 <<< (WORD_BITS - 1));
      if (v > hi) begin
         ovf = 1'b1;
         return hi[WORD_BITS-1:0];
      end
      if (v < lo) begin
         ovf = 1'b1;
         return lo[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
   endfunction

   // Signed quotient truncated toward zero, numerator prescaled by FRAC
   function automatic logic signed [127:0] fx_quot(input logic signed [127:0] num,
                                                  input logic signed [127:0] den);
      logic [127:0] mag;
      logic [127:0] q;
      mag = num < 0 ? -num : num;
      q = (mag << FRAC) / den;
      return num < 0 ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [127:0] isqrt(input logic [127:0] v);
      logic [127:0] r;
      logic [127:0] b;
      r = 0;
      b = 128'd1 << 126;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Expected result of one word
   function automatic rsp_word_type alu_result(input req_word_type w);
      rsp_word_type r;
      logic signed [127:0] a, b, c, d, den, rnd;
      bit ovf;
      a = w.x_real; b = w.x_imag; c = w.y_real; d = w.y_imag;
      rnd = 128'sd1 <<< (FRAC - 1);
      r = '0;
      ovf = 1'b0;
      case (w.op)
         OP_ADD: begin
            r.res_real = clamp_word(a + c, ovf);
            r.res_imag = clamp_word(b + d, ovf);
         end
         OP_SUB: begin
            r.res_real = clamp_word(a - c, ovf);
            r.res_imag = clamp_word(b - d, ovf);
         end
         OP_MUL: begin
            r.res_real = clamp_word((a * c - b * d + rnd) >>> FRAC, ovf);
            r.res_imag = clamp_word((a * d + b * c + rnd) >>> FRAC, ovf);
         end
         OP_DIV: begin
            den = c * c + d * d;
            if (den == 0) begin
               r.status = ST_DIV0;
            end else begin
               r.res_real = clamp_word(fx_quot(a * c + b * d, den), ovf);
               r.res_imag = clamp_word(fx_quot(b * c - a * d, den), ovf);
            end
         end
         OP_NEG: begin
            r.res_real = clamp_word(-a, ovf);
            r.res_imag = clamp_word(-b, ovf);
         end
         OP_CONJ: begin
            r.res_real = clamp_word(a, ovf);
            r.res_imag = clamp_word(-b, ovf);
         end
         OP_ABS:  r.res_real = clamp_word($signed(isqrt(a * a + b * b)), ovf);
         OP_EQ:   r.cmp_true = (a == c && b == d);
         OP_LT:   r.cmp_true = (a < c || (a == c && b < d));
         OP_LE:   r.cmp_true = (a < c || (a == c && b <= d));
         OP_GT:   r.cmp_true = (a > c || (a == c && b > d));
         OP_GE:   r.cmp_true = (a > c || (a == c && b >= d));
         default: ;
      endcase
      if (ovf && r.status == ST_OK) r.status = ST_SAT;
      return r;
   endfunction

   // Mostly short gaps, a few long ones, some runs with none
   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Present one word and hold it until accepted; valid drops only in a gap
   task automatic send_word(input req_word_type w);
      int g;
      g = drv_gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(alu_result(w));
      op_seen[w.op]++;
      n_sent++;
      @(negedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] rand_operand();
      int p;
      p = $urandom_range(9);
      case (p)
         0: return {1'b0, {(WORD_BITS - 1){1'b1}}};
         1: return {1'b1, {(WORD_BITS - 1){1'b0}}};
         2: return '0;
         3: return $urandom_range(255) << FRAC;
         4: return -($urandom_range(255) << FRAC);
         5: return $signed(16'($urandom));
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type rand_word();
      req_word_type w;
      w.op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12))
                                       : 4'($urandom_range(11));
      w.x_real = rand_operand();
      w.x_imag = rand_operand();
      w.y_real = rand_operand();
      w.y_imag = ($urandom_range(4) == 0) ? '0 : rand_operand();
      // Equal operands so the comparisons hit their tie cases
      if (w.op >= OP_EQ && $urandom_range(2) == 0) begin
         w.y_real = w.x_real;
         if ($urandom_range(1) == 0) w.y_imag = w.x_imag;
      end
      return w;
   endfunction

   // Result checker
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result word %h", rsp_word);
            n_errors++;
         end else begin
            exp_w = expected_q.pop_front();
            n_checked++;
            if (rsp_word.res_real !== exp_w.res_real) begin
               $error("res_real exp %h got %h", exp_w.res_real, rsp_word.res_real);
               n_errors++;
            end
            if (rsp_word.res_imag !== exp_w.res_imag) begin
               $error("res_imag exp %h got %h", exp_w.res_imag, rsp_word.res_imag);
               n_errors++;
            end
            if (rsp_word.cmp_true !== exp_w.cmp_true) begin
               $error("cmp_true exp %b got %b", exp_w.cmp_true, rsp_word.cmp_true);
               n_errors++;
            end
            if (rsp_word.status !== exp_w.status) begin
               $error("status exp %0d got %0d", exp_w.status, rsp_word.status);
               n_errors++;
            end
         end
      end
   end

   // Receiver: random stalls, or one long hold-off on request
   initial begin
      int g;
      int k;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_stall) begin
            rsp_ready <= 1'b0;
            for (k = 0; k < 150; k++) @(negedge clock);
            long_stall = 1'b0;
         end
         g = gap_len();
         if (g == 0) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(3) == 0);
            repeat (g) @(negedge clock);
         end
      end
   end

   // Watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cyc <= 0;
      else
         idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WD_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      logic [WORD_BITS-1:0] ext[4];
      req_word_type w;
      int o;
      ext[0] = {1'b0, {(WORD_BITS - 1){1'b1}}};
      ext[1] = {1'b1, {(WORD_BITS - 1){1'b0}}};
      ext[2] = '0;
      ext[3] = 32'h0001_0000;
      // Every opcode on max/min operands: overflow paths
      for (o = 0; o < 16; o++) begin
         w.op = 4'(o);
         w.x_real = ext[o % 2]; w.x_imag = ext[1];
         w.y_real = ext[(o + 1) % 2]; w.y_imag = ext[0];
         send_word(w);
      end
      // Divide by zero
      w = '{op: OP_DIV, x_real: ext[3], x_imag: ext[0], y_real: '0, y_imag: '0};
      send_word(w);
      // Scalar divide, saturating multiply, equal-operand compares
      w = '{op: OP_DIV, x_real: ext[3], x_imag: ext[3], y_real: 32'h0002_0000, y_imag: '0};
      send_word(w);
      w = '{op: OP_MUL, x_real: ext[3], x_imag: ext[3], y_real: ext[3], y_imag: ext[1]};
      send_word(w);
      w = '{op: OP_EQ, x_real: ext[1], x_imag: ext[0], y_real: ext[1], y_imag: ext[0]};
      send_word(w);
      w.op = OP_LE; send_word(w);
      w.op = OP_GE; send_word(w);
      w = '{op: OP_ABS, x_real: ext[1], x_imag: ext[1], y_real: '0, y_imag: '0};
      send_word(w);
      w = '{op: OP_ADD, x_real: '1, x_imag: '1, y_real: '1, y_imag: '1};
      send_word(w);
   endtask

   task automatic test_random(input int n);
      int i;
      for (i = 0; i < n; i++) send_word(rand_word());
   endtask

   // Output held off while input keeps coming back-to-back
   task automatic test_backpressure();
      int i;
      drv_gaps = 1'b0;
      long_stall = 1'b1;
      for (i = 0; i < 100; i++) send_word(rand_word());
      drv_gaps = 1'b1;
   endtask

   initial begin
      int k;
      int ops_hit;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(800);
      test_backpressure();
      test_random(925);
      req_valid <= 1'b0;
      // Drain
      k = 0;
      while (expected_q.size() != 0 && k < WD_LIMIT) begin
         @(posedge clock);
         k++;
      end
      repeat (DRAIN_CYC) @(posedge clock);
      ops_hit = 0;
      foreach (op_seen[o]) if (op_seen[o] != 0) ops_hit++;
      $display("Sent %0d words over %0d opcodes, checked %0d results.",
               n_sent, ops_hit, n_checked);
      if (n_errors == 0 && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/cau_pkg.sv
design/cau_front.sv
design/cau_iter.sv
design/cau_back.sv
design/complex_arithmetic_unit_core.sv
verif/tb_complex_arithmetic_unit_core.sv
